[hdl/fjiop_pkg.sv]
`timescale 1ns / 1ps

package fjiop_pkg;

    localparam logic [1:0] EV_KEY_BYTE = 2'd0;
    localparam logic [1:0] EV_ENTRY    = 2'd1;
    localparam logic [1:0] EV_ACCEPT   = 2'd2;
    localparam logic [1:0] EV_REJECT   = 2'd3;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_F      = 8'h66;

    localparam logic [2:0] SKIP_TRUE  = 3'd3;
    localparam logic [2:0] SKIP_FALSE = 3'd4;

    localparam logic [31:0] MAG_CAP = 32'h8000_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

    // result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    typedef struct packed {
        logic [1:0]         event_kind;
        logic [7:0]         key_byte;
        logic signed [31:0] entry_value;
        logic [5:0]         entry_index;
        logic [6:0]         entry_total;
        logic               last_of_run;
    } result_t;

endpackage

[hdl/fjiop_step.sv]
`timescale 1ns / 1ps

module fjiop_step #(
    parameter int ENTRY_LIMIT  = 64,
    parameter int KEY_CAPACITY = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         text_byte,
    output fjiop_pkg::result_t res0,
    output fjiop_pkg::result_t res1,
    output logic [1:0]         res_n
);
    import fjiop_pkg::*;

    localparam int EW  = $clog2(ENTRY_LIMIT + 1);
    localparam int KW  = $clog2(KEY_CAPACITY);
    localparam int EXT = (EW > 7) ? EW : 7;
    localparam logic [EW-1:0] ENT_LAST = EW'(ENTRY_LIMIT - 1);
    localparam logic [KW-1:0] KEY_MAX  = KW'(KEY_CAPACITY - 1);

    typedef enum logic [3:0] {
        PH_SEEK, PH_BETWEEN, PH_KEY, PH_COLON, PH_SPACE,
        PH_SIGN, PH_DIGITS, PH_LITERAL, PH_DRAIN
    } phase_t;

    typedef enum logic [1:0] {
        TAIL_NONE, TAIL_ACCEPT, TAIL_REJECT, TAIL_BETWEEN
    } tail_t;

    phase_t        phase_reg, phase_next;
    logic [KW-1:0] klen_reg, klen_next;
    logic [2:0]    skip_reg, skip_next;
    logic          neg_reg, neg_next;
    logic          seen_reg, seen_next;
    logic [31:0]   acc_reg, acc_next;
    logic [EW-1:0] ent_reg, ent_next;

    logic          is_digit, is_space, vstart, fin, key_emit;
    logic [31:0]   fin_val, num_val, dig_val;
    logic [35:0]   dig_sum;
    logic [2:0]    skip_dec;
    tail_t         tail;
    logic [EXT-1:0] ent_old_ext, ent_new_ext;
    result_t       r_fin, r_key, r_tail;

    assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
    assign is_space = (text_byte == CH_SPACE) || ((text_byte >= CH_TAB) && (text_byte <= CH_CR));

    // acc*10 + digit, magnitude capped at 2^31
    assign dig_sum = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                   + {32'd0, text_byte[3:0] - CH_ZERO[3:0]};
    assign dig_val = (dig_sum > {4'd0, MAG_CAP}) ? MAG_CAP : dig_sum[31:0];
    assign num_val = neg_reg ? (32'd0 - acc_reg) : ((acc_reg > POS_MAX) ? POS_MAX : acc_reg);
    assign skip_dec = (skip_reg != 3'd0) ? (skip_reg - 3'd1) : skip_reg;

    always_comb
    begin
        phase_next = phase_reg;
        klen_next  = klen_reg;
        skip_next  = skip_reg;
        neg_next   = neg_reg;
        seen_next  = seen_reg;
        acc_next   = acc_reg;
        ent_next   = ent_reg;
        vstart     = 1'b0;
        fin        = 1'b0;
        fin_val    = '0;
        key_emit   = 1'b0;
        tail       = TAIL_NONE;

        unique case (phase_reg)
            PH_SEEK:
            begin
                if (text_byte == CH_LBRACE)
                    phase_next = PH_BETWEEN;
                else if (text_byte == CH_NUL)
                    tail = TAIL_ACCEPT;
            end
            PH_BETWEEN:
                tail = TAIL_BETWEEN;
            PH_KEY:
            begin
                if (text_byte == CH_NUL)
                    tail = TAIL_REJECT;
                else if (text_byte == CH_QUOTE)
                    phase_next = PH_COLON;
                else if (klen_reg < KEY_MAX)
                begin
                    key_emit  = 1'b1;
                    klen_next = klen_reg + KW'(1);
                end
            end
            PH_COLON:
            begin
                if (text_byte == CH_COLON)
                    phase_next = PH_SPACE;
                else if (text_byte == CH_NUL)
                    vstart = 1'b1;
            end
            PH_SPACE:
                vstart = !is_space;
            PH_SIGN:
            begin
                if (is_digit)
                begin
                    acc_next   = dig_val;
                    seen_next  = 1'b1;
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    fin  = 1'b1;
                    tail = TAIL_REJECT;
                end
            end
            PH_DIGITS:
            begin
                if (is_digit)
                begin
                    acc_next  = dig_val;
                    seen_next = 1'b1;
                end
                else
                begin
                    fin     = 1'b1;
                    fin_val = num_val;
                    tail    = TAIL_BETWEEN;
                end
            end
            PH_LITERAL:
            begin
                if (text_byte == CH_NUL)
                    tail = TAIL_ACCEPT;
                else
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 3'd0)
                        phase_next = PH_BETWEEN;
                end
            end
            default:
            begin
                if (text_byte == CH_NUL)
                    tail = TAIL_ACCEPT;
                else
                    phase_next = PH_DRAIN;
            end
        endcase

        // drain state: terminator starts a new document silently
        if ((phase_reg != PH_SEEK) && (phase_reg != PH_BETWEEN) && (phase_reg != PH_KEY)
            && (phase_reg != PH_COLON) && (phase_reg != PH_SPACE) && (phase_reg != PH_SIGN)
            && (phase_reg != PH_DIGITS) && (phase_reg != PH_LITERAL))
            tail = TAIL_NONE;

        if (vstart)
        begin
            priority if ((text_byte == CH_T) || (text_byte == CH_F))
            begin
                fin        = 1'b1;
                fin_val    = (text_byte == CH_T) ? 32'd1 : 32'd0;
                skip_next  = (text_byte == CH_T) ? SKIP_TRUE : SKIP_FALSE;
                phase_next = PH_LITERAL;
            end
            else if ((text_byte == CH_PLUS) || (text_byte == CH_MINUS))
            begin
                neg_next   = (text_byte == CH_MINUS);
                phase_next = PH_SIGN;
            end
            else if (is_digit)
            begin
                acc_next   = dig_val;
                seen_next  = 1'b1;
                phase_next = PH_DIGITS;
            end
            else
            begin
                fin  = 1'b1;
                tail = TAIL_BETWEEN;
            end
        end

        if (fin)
        begin
            neg_next  = 1'b0;
            seen_next = 1'b0;
            acc_next  = '0;
            ent_next  = ent_reg + EW'(1);
            if (ent_reg == ENT_LAST)
                tail = TAIL_ACCEPT;
        end

        if (tail == TAIL_BETWEEN)
        begin
            priority if ((text_byte == CH_NUL) || (text_byte == CH_RBRACE))
                tail = TAIL_ACCEPT;
            else if (is_space || (text_byte == CH_COMMA))
                tail = TAIL_NONE;
            else if (text_byte == CH_QUOTE)
            begin
                tail       = TAIL_NONE;
                klen_next  = '0;
                phase_next = PH_KEY;
            end
            else
                tail = TAIL_REJECT;
        end

        // drain-state terminator and document end both reset the context
        if ((tail == TAIL_ACCEPT) || (tail == TAIL_REJECT)
            || ((phase_reg == PH_DRAIN) && (text_byte == CH_NUL)))
        begin
            if (text_byte == CH_NUL)
            begin
                phase_next = PH_SEEK;
                klen_next  = '0;
                skip_next  = '0;
                neg_next   = 1'b0;
                seen_next  = 1'b0;
                acc_next   = '0;
                ent_next   = '0;
            end
            else
                phase_next = PH_DRAIN;
        end
    end

    always_comb
    begin
        ent_old_ext = EXT'(ent_reg);
        ent_new_ext = EXT'(ent_reg + (fin ? EW'(1) : EW'(0)));

        r_fin             = '0;
        r_fin.event_kind  = EV_ENTRY;
        r_fin.entry_value = fin_val;
        r_fin.entry_index = ent_old_ext[5:0];

        r_key             = '0;
        r_key.event_kind  = EV_KEY_BYTE;
        r_key.key_byte    = text_byte;

        r_tail            = '0;
        if (tail == TAIL_REJECT)
            r_tail.event_kind = EV_REJECT;
        else
        begin
            r_tail.event_kind  = EV_ACCEPT;
            r_tail.entry_total = ent_new_ext[6:0];
        end
        r_tail.last_of_run = 1'b1;

        res1 = r_tail;
        if (fin)
        begin
            res0             = r_fin;
            res0.last_of_run = !((tail == TAIL_ACCEPT) || (tail == TAIL_REJECT));
        end
        else if (key_emit)
        begin
            res0             = r_key;
            res0.last_of_run = 1'b1;
        end
        else
            res0 = r_tail;

        res_n = {1'b0, fin} + {1'b0, key_emit}
              + {1'b0, (tail == TAIL_ACCEPT) || (tail == TAIL_REJECT)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEEK;
            klen_reg  <= '0;
            skip_reg  <= '0;
            neg_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            acc_reg   <= '0;
            ent_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            klen_reg  <= klen_next;
            skip_reg  <= skip_next;
            neg_reg   <= neg_next;
            seen_reg  <= seen_next;
            acc_reg   <= acc_next;
            ent_reg   <= ent_next;
        end
    end

endmodule

[hdl/fjiop_queue.sv]
`timescale 1ns / 1ps

module fjiop_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  fjiop_pkg::result_t push0,
    input  fjiop_pkg::result_t push1,
    input  logic [1:0]         push_n,
    output logic               room,
    output logic               head_valid,
    input  logic               head_ready,
    output fjiop_pkg::result_t head
);
    import fjiop_pkg::*;

    result_t        mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [Q_CW-1:0] cnt_reg, cnt_next;
    logic            pop;

    // room for the two words one byte can produce
    assign room       = (cnt_reg <= Q_CW'(Q_DEPTH - 2));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem[rd_reg];
    assign pop        = head_valid && head_ready;

    assign wr_next  = wr_reg + Q_AW'(push_n);
    assign rd_next  = rd_reg + (pop ? Q_AW'(1) : Q_AW'(0));
    assign cnt_next = cnt_reg + Q_CW'(push_n) - (pop ? Q_CW'(1) : Q_CW'(0));

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            mem[wr_reg] <= push0;
        if (push_n == 2'd2)
            mem[wr_reg + Q_AW'(1)] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[hdl/flat_json_int_object_parser.sv]
`timescale 1ns / 1ps
// each byte's words are pushed into the registered result queue in the cycle the byte is taken
// throughput: one byte per cycle while text_ready is high; words leave the four-deep
// result queue one per cycle while event_ready is high, so runs of two-word bytes get stalled
// text_ready drops while the result queue cannot take two more words
// reset (rst_n low, asynchronous) empties the queue and starts a fresh document
module flat_json_int_object_parser #(
    parameter int ENTRY_LIMIT  = 64,
    parameter int KEY_CAPACITY = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               text_valid,
    output logic               text_ready,
    input  logic [7:0]         text_byte,
    output logic               event_valid,
    input  logic               event_ready,
    output logic [1:0]         event_kind,
    output logic [7:0]         key_byte,
    output logic signed [31:0] entry_value,
    output logic [5:0]         entry_index,
    output logic [6:0]         entry_total,
    output logic               last_of_run
);
    import fjiop_pkg::*;

    logic       accept;
    logic [1:0] res_n, push_n;
    result_t    res0, res1, head;

    assign accept = text_valid && text_ready;
    assign push_n = accept ? res_n : 2'd0;

    fjiop_step #(
        .ENTRY_LIMIT  (ENTRY_LIMIT),
        .KEY_CAPACITY (KEY_CAPACITY)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .text_byte (text_byte),
        .res0      (res0),
        .res1      (res1),
        .res_n     (res_n)
    );

    fjiop_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push0      (res0),
        .push1      (res1),
        .push_n     (push_n),
        .room       (text_ready),
        .head_valid (event_valid),
        .head_ready (event_ready),
        .head       (head)
    );

    assign event_kind  = head.event_kind;
    assign key_byte    = head.key_byte;
    assign entry_value = head.entry_value;
    assign entry_index = head.entry_index;
    assign entry_total = head.entry_total;
    assign last_of_run = head.last_of_run;

    a_value_only_on_entry: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && (event_kind != EV_ENTRY) |-> entry_value == 32'sd0)
        else $error("value on a non-entry word");

    a_single_word_kinds_last: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && (event_kind != EV_ENTRY) |-> last_of_run)
        else $error("key or verdict word not last of its run");

    a_stall_means_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        !text_ready |-> event_valid)
        else $error("input stalled with empty result queue");

    a_two_words_need_room: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (res_n == 2'd2) |-> !res0.last_of_run && res1.last_of_run)
        else $error("two-word run with wrong last marks");

endmodule
